[sv/gbl_pkg.sv]
// Shared types, constants and helpers for the separable 5-tap Gaussian blur.
// Used by every module of the block except gbl_fifo; depends on nothing else.
package gbl_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  // Queue depths: between front and back, and for finished words
  localparam int QDEPTH = 4;
  localparam int ODEPTH = 8;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_NEAR    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FAR     = 3'd4;

  // Register reset values
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1024;
  localparam logic [15:0] RST_COEF_CENTER  = 16'd26386;
  localparam logic [15:0] RST_COEF_NEAR    = 16'd16004;
  localparam logic [15:0] RST_COEF_FAR     = 16'd3570;

  // Input word opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int NTAPS    = 5;
  localparam int MIR_BITS = 16;

  typedef struct packed {
    logic        op;
    logic [15:0] pixel;
  } in_word_t;

  typedef struct packed {
    logic [15:0] filtered;
    logic        last;
  } out_word_t;

  // Per-item control handed from front to back
  typedef struct packed {
    logic                  col_valid; // vertical pass has real rows
    logic                  emit;      // a result word comes out
    logic                  last;      // final pixel of the image
    logic [NTAPS-1:0]      use_cur;   // vertical tap takes the incoming pixel
    logic [NTAPS-1:0][1:0] bank;      // row bank of each vertical tap
    logic [NTAPS-1:0][2:0] widx;      // window slot of each horizontal tap
  } ctrl_t;

  localparam int CTRL_BITS = $bits(ctrl_t);

  // Window slot for horizontal tap at position x around column oc, mirrored
  // at both row ends without repeating the edge pixel.
  function automatic logic [2:0] col_tap(input logic signed [MIR_BITS-1:0] x,
                                         input logic signed [MIR_BITS-1:0] n,
                                         input logic signed [MIR_BITS-1:0] oc);
    logic signed [MIR_BITS-1:0] m;
    logic signed [MIR_BITS-1:0] nm1;
    logic signed [MIR_BITS-1:0] i;
    nm1 = n - 16'sd1;
    m = x;
    if (m < 16'sd0) m = -m;
    if (m > nm1) m = (nm1 <<< 1) - m;
    if (m < 16'sd0) m = 16'sd0;
    if (m > nm1) m = nm1;
    i = m - oc + 16'sd2;
    if (i < 16'sd0) i = 16'sd0;
    if (i > 16'sd4) i = 16'sd4;
    return i[2:0];
  endfunction

endpackage

[sv/gbl_fifo.sv]
// Small register FIFO used between front and back and for result words.
// Depends on nothing; the caller never pushes when it is full.
module gbl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PB-1:0]    wptr;
  logic [PB-1:0]    rptr;
  logic             do_pop;

  assign empty  = (level == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) wptr <= (wptr == PB'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (do_pop) rptr <= (rptr == PB'(DEPTH-1)) ? '0 : rptr + 1'b1;
      level <= level + (push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
    end
  end
endmodule

[sv/gbl_front.sv]
// Front end: accepts words, tracks raster position, holds the four row
// banks and works out tap selection. Depends on gbl_pkg.
module gbl_front #(
  parameter int MAX_WIDTH  = gbl_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gbl_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  gbl_pkg::in_word_t                     din,
  input  logic [10:0]                           image_width,
  input  logic [15:0]                           image_height,
  input  logic [$clog2(gbl_pkg::QDEPTH+1)-1:0]  q_level,
  output logic                                  fw_valid,
  output gbl_pkg::ctrl_t                        fw_ctrl,
  output logic [PIXEL_BITS-1:0]                 fw_cur,
  output logic [3:0][PIXEL_BITS-1:0]            fw_rd
);
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int QB = $clog2(gbl_pkg::QDEPTH + 1);

  logic [CB-1:0]         in_col, out_col;
  logic [16:0]           in_row, out_row;
  logic [WB-1:0]         w;
  logic [15:0]           h;
  logic [16:0]           h17, r;
  logic                  accept, ignore, live, fwd, col_ok, store;
  logic [PIXEL_BITS-1:0] pix;
  logic                  r_is0, r_is1, r_last, r_last1;
  logic [2:0]            lag [gbl_pkg::NTAPS];
  gbl_pkg::ctrl_t        ctrl;
  logic [WB:0]           ic_inc, oc_inc;
  logic                  ic_wrap, oc_wrap;
  logic [CB-1:0]         ic_n, oc_n;
  logic [16:0]           ir_n, or_n;
  logic                  done;
  logic signed [gbl_pkg::MIR_BITS-1:0] oc_s, w_s;

  // effective image size
  always_comb begin
    if (image_width < 11'd3) w = WB'(3);
    else if (32'(image_width) > MAX_WIDTH) w = WB'(MAX_WIDTH);
    else w = WB'(image_width);
    h = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  assign h17    = {1'b0, h};
  assign full   = ({1'b0, q_level} + (QB+1)'(fw_valid)) >= (QB+1)'(gbl_pkg::QDEPTH);
  assign accept = push && !full;
  assign ignore = (in_row < h17) && (din.op == gbl_pkg::OP_DRAIN);
  assign live   = accept && !ignore;
  assign fwd    = live && (in_row >= 17'd2);
  assign col_ok = in_row < (h17 + 17'd2);
  assign store  = live && (in_row < h17);
  assign pix    = PIXEL_BITS'(din.pixel);

  // vertical tap lags, mirrored at top and bottom
  assign r       = in_row - 17'd2;
  assign r_is0   = (r == 17'd0);
  assign r_is1   = (r == 17'd1);
  assign r_last  = (r == h17 - 17'd1);
  assign r_last1 = (r == h17 - 17'd2);

  always_comb begin
    lag[0] = r_is0 ? 3'd0 : (r_is1 ? 3'd2 : 3'd4);
    lag[1] = r_is0 ? 3'd1 : 3'd3;
    lag[2] = 3'd2;
    lag[3] = r_last ? 3'd3 : 3'd1;
    lag[4] = r_last ? 3'd4 : (r_last1 ? 3'd2 : 3'd0);
  end

  // control word for the back end
  assign oc_s = signed'(gbl_pkg::MIR_BITS'(out_col));
  assign w_s  = signed'(gbl_pkg::MIR_BITS'(w));

  always_comb begin
    ctrl.col_valid = col_ok;
    ctrl.emit      = !((in_row == 17'd2) && (in_col < CB'(2)));
    ctrl.last      = (out_row == h17 - 17'd1) && (WB'(out_col) == w - WB'(1));
    for (int d = 0; d < gbl_pkg::NTAPS; d++) begin
      ctrl.use_cur[d] = (lag[d] == 3'd0);
      ctrl.bank[d]    = in_row[1:0] - lag[d][1:0];
      ctrl.widx[d]    = gbl_pkg::col_tap(oc_s + gbl_pkg::MIR_BITS'(d - 2), w_s, oc_s);
    end
  end

  // position counters
  always_comb begin
    ic_inc  = (WB+1)'(in_col) + 1'b1;
    ic_wrap = ic_inc >= (WB+1)'(w);
    ic_n    = ic_wrap ? '0 : CB'(ic_inc);
    ir_n    = ic_wrap ? in_row + 17'd1 : in_row;
    oc_inc  = (WB+1)'(out_col) + 1'b1;
    oc_wrap = oc_inc >= (WB+1)'(w);
    oc_n    = out_col;
    or_n    = out_row;
    if (fwd && ctrl.emit) begin
      oc_n = oc_wrap ? '0 : CB'(oc_inc);
      or_n = oc_wrap ? out_row + 17'd1 : out_row;
    end
    done = (ir_n > h17 + 17'd2) || ((ir_n == h17 + 17'd2) && (ic_n >= CB'(2)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (live) begin
      if (done) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        in_col  <= ic_n;
        in_row  <= ir_n;
        out_col <= oc_n;
        out_row <= or_n;
      end
    end
  end

  // four row banks, row r lives in bank r mod 4; read before write
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (store && (in_row[1:0] == 2'(b))) mem[in_col] <= pix;
      if (accept) fw_rd[b] <= mem[in_col];
    end
  end

  // stage register lined up with the bank read data
  always_ff @(posedge clk) begin
    if (rst) fw_valid <= 1'b0;
    else     fw_valid <= fwd;
  end

  always_ff @(posedge clk) begin
    if (fwd) begin
      fw_ctrl <= ctrl;
      fw_cur  <= (in_row < h17) ? pix : '0;
    end
  end
endmodule

[sv/gbl_back.sv]
// Back end: vertical pass, column window, horizontal pass, rounding and
// saturation, in a fixed five-stage pipeline. Depends on gbl_pkg.
module gbl_back #(
  parameter int PIXEL_BITS = gbl_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  gbl_pkg::ctrl_t                        q_ctrl,
  input  logic [PIXEL_BITS-1:0]                 q_cur,
  input  logic [3:0][PIXEL_BITS-1:0]            q_rd,
  output logic                                  q_pop,
  input  logic [15:0]                           coef_center,
  input  logic [15:0]                           coef_near,
  input  logic [15:0]                           coef_far,
  input  logic [$clog2(gbl_pkg::ODEPTH+1)-1:0]  o_level,
  output logic                                  o_push,
  output gbl_pkg::out_word_t                    o_word
);
  localparam int PB = PIXEL_BITS;
  localparam int LB = $clog2(gbl_pkg::ODEPTH + 1);

  typedef struct packed {
    logic [PB:0]   far;
    logic [PB:0]   near;
    logic [PB-1:0] mid;
  } pairs_t;

  typedef struct packed {
    logic [PB+16:0] far;
    logic [PB+16:0] near;
    logic [PB+15:0] mid;
  } prods_t;

  logic [4:0]       sv;            // stage valids
  gbl_pkg::ctrl_t   c1, c2, c3, c4, c5;
  pairs_t           p1, p4, pr1, pr4;
  prods_t           m2, m5;
  logic [PB-1:0]    win [gbl_pkg::NTAPS];
  logic [PB-1:0]    v [gbl_pkg::NTAPS];
  logic [PB-1:0]    t [gbl_pkg::NTAPS];
  logic [PB-1:0]    vres, hres;

  // round half up, drop 16 fraction bits, saturate
  function automatic logic [PB-1:0] finish(input prods_t m);
    logic [PB+18:0] s;
    s = (PB+19)'(m.far) + (PB+19)'(m.near) + (PB+19)'(m.mid) + (PB+19)'(32768);
    return (|s[PB+18:PB+16]) ? '1 : s[PB+15:16];
  endfunction

  // credit check keeps the output queue from overflowing
  assign q_pop = q_valid &&
                 (((LB+1)'(o_level) + (LB+1)'($countones(sv))) < (LB+1)'(gbl_pkg::ODEPTH));

  // vertical taps and pair sums
  always_comb begin
    for (int d = 0; d < gbl_pkg::NTAPS; d++)
      v[d] = q_ctrl.use_cur[d] ? q_cur : q_rd[q_ctrl.bank[d]];
    pr1.far  = {1'b0, v[0]} + {1'b0, v[4]};
    pr1.near = {1'b0, v[1]} + {1'b0, v[3]};
    pr1.mid  = v[2];
  end

  // horizontal taps from the freshly shifted window
  always_comb begin
    for (int d = 0; d < gbl_pkg::NTAPS; d++) t[d] = win[c3.widx[d]];
    pr4.far  = {1'b0, t[0]} + {1'b0, t[4]};
    pr4.near = {1'b0, t[1]} + {1'b0, t[3]};
    pr4.mid  = t[2];
  end

  assign vres = c2.col_valid ? finish(m2) : '0;
  assign hres = finish(m5);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) sv <= '0;
    else     sv <= {sv[3:0], q_pop};
  end

  // column window, oldest in slot 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gbl_pkg::NTAPS; i++) win[i] <= '0;
    end else if (sv[1]) begin
      for (int i = 0; i < gbl_pkg::NTAPS - 1; i++) win[i] <= win[i+1];
      win[gbl_pkg::NTAPS-1] <= vres;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    c1 <= q_ctrl;
    p1 <= pr1;
    c2 <= c1;
    m2.far  <= coef_far  * p1.far;
    m2.near <= coef_near * p1.near;
    m2.mid  <= coef_center * p1.mid;
    c3 <= c2;
    c4 <= c3;
    p4 <= pr4;
    c5 <= c4;
    m5.far  <= coef_far  * p4.far;
    m5.near <= coef_near * p4.near;
    m5.mid  <= coef_center * p4.mid;
  end

  assign o_push          = sv[4] && c5.emit;
  assign o_word.filtered = 16'(hres);
  assign o_word.last     = c5.last;
endmodule

[sv/separable_gaussian_blur_5tap_top.sv]
// Separable 5x5 Gaussian blur on a raster pixel stream. Push one word per
// clock: op pixel carries the next pixel in raster order, op drain is a tick
// that only flushes. Results come out in raster order two rows and two pixels
// behind the inputs, so after the last pixel of an image send 2*width+2 drain
// ticks; last marks the final result. The block takes one word per clock
// while full is low and gives one result per clock while results are popped;
// words pass through the front end and its four row banks, a work queue,
// the five pipeline stages of the back end and a result queue.
// Registers: 0 width, 1 height, 2 center, 3 near, 4 far weight (Q0.16); write
// them between images. Row banks need no clearing after reset.
// Depends on gbl_pkg, gbl_fifo, gbl_front and gbl_back.
module separable_gaussian_blur_5tap_top #(
  parameter int MAX_WIDTH  = gbl_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = gbl_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  gbl_pkg::in_word_t                 din,
  output logic                              empty,
  input  logic                              pop,
  output gbl_pkg::out_word_t                dout,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gbl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [15:0]                       cfg_data
);
  localparam int QW = gbl_pkg::CTRL_BITS + 5 * PIXEL_BITS;
  localparam int OW = $bits(gbl_pkg::out_word_t);

  logic [10:0] image_width;
  logic [15:0] image_height, coef_center, coef_near, coef_far;

  logic                                 fw_valid;
  gbl_pkg::ctrl_t                       fw_ctrl, q_ctrl;
  logic [PIXEL_BITS-1:0]                fw_cur, q_cur;
  logic [3:0][PIXEL_BITS-1:0]           fw_rd, q_rd;
  logic [QW-1:0]                        q_rdata;
  logic                                 q_empty, q_pop;
  logic [$clog2(gbl_pkg::QDEPTH+1)-1:0] q_level;
  logic [$clog2(gbl_pkg::ODEPTH+1)-1:0] o_level;
  logic                                 o_push;
  gbl_pkg::out_word_t                   o_word;
  logic [OW-1:0]                        o_rdata;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gbl_pkg::RST_IMAGE_WIDTH;
      image_height <= gbl_pkg::RST_IMAGE_HEIGHT;
      coef_center  <= gbl_pkg::RST_COEF_CENTER;
      coef_near    <= gbl_pkg::RST_COEF_NEAR;
      coef_far     <= gbl_pkg::RST_COEF_FAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gbl_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        gbl_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        gbl_pkg::REG_COEF_CENTER:  coef_center  <= cfg_data;
        gbl_pkg::REG_COEF_NEAR:    coef_near    <= cfg_data;
        gbl_pkg::REG_COEF_FAR:     coef_far     <= cfg_data;
        default: ;
      endcase
    end
  end

  gbl_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst, .push, .full, .din,
    .image_width, .image_height, .q_level,
    .fw_valid, .fw_ctrl, .fw_cur, .fw_rd
  );

  // work queue between front and back
  gbl_fifo #(.WIDTH(QW), .DEPTH(gbl_pkg::QDEPTH)) u_work_q (
    .clk, .rst,
    .push  (fw_valid),
    .wdata ({fw_ctrl, fw_cur, fw_rd}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .level (q_level)
  );

  assign {q_ctrl, q_cur, q_rd} = q_rdata;

  gbl_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk, .rst,
    .q_valid (!q_empty),
    .q_ctrl, .q_cur, .q_rd, .q_pop,
    .coef_center, .coef_near, .coef_far,
    .o_level, .o_push, .o_word
  );

  // result queue
  gbl_fifo #(.WIDTH(OW), .DEPTH(gbl_pkg::ODEPTH)) u_out_q (
    .clk, .rst,
    .push  (o_push),
    .wdata (o_word),
    .pop   (pop),
    .rdata (o_rdata),
    .empty (empty),
    .level (o_level)
  );

  assign dout = gbl_pkg::out_word_t'(o_rdata);
endmodule

[sv/gbl_checker.sv]
// Port-level checks for the blur top level, attached by bind.
// Depends on gbl_pkg and separable_gaussian_blur_5tap_top.
module gbl_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input gbl_pkg::out_word_t dout
);
  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

  // back-pressure only builds up from an accepted word
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted word");

  // results only leave through pop
  a_empty_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> $past(pop))
    else $error("result lost without pop");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(dout)))
    else $error("waiting result changed");
endmodule

bind separable_gaussian_blur_5tap_top gbl_checker u_gbl_checker (.*);
